// ===== hdl/rsfrr_pkg.sv =====
// Shared types and constants for the FIFO / round-robin request scheduler.
package rsfrr_pkg;

  localparam int CID_W      = 6;
  localparam int ST_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int LIMIT_W    = 7;
  localparam int PEND_W     = 7;

  localparam logic FUNC_ENQ  = 1'b0;
  localparam logic FUNC_TAKE = 1'b1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_RR   = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_LIMIT = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_NONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd14;
  localparam logic [PEND_W-1:0]  PENDING_MAX = 7'd127;

  typedef struct packed {
    logic             func;
    logic [CID_W-1:0] client_id;
  } req_word_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [CID_W-1:0] granted_client;
  } rsp_word_t;

  // Result of the round-robin scan unit
  typedef struct packed {
    logic             done;
    logic             found;
    logic [CID_W-1:0] client;
  } scan_res_t;

endpackage

// ===== hdl/rsfrr_scan.sv =====
// Round-robin scan over the per-client pending flags, eight positions a cycle (all of them when there are fewer).
module rsfrr_scan #(
  parameter int ACT = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [$clog2(ACT)-1:0] start_pos,
  input  logic [ACT-1:0]        flags,
  output rsfrr_pkg::scan_res_t  res
);
  import rsfrr_pkg::*;

  localparam int AW     = $clog2(ACT);
  localparam int PW     = AW + 1;
  localparam int LANES  = (ACT < 8) ? ACT : 8;
  localparam int NCHUNK = (ACT + LANES - 1) / LANES;
  localparam int CHW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

  logic           busy;
  logic [AW-1:0]  pos;
  logic [CHW-1:0] chunk;
  logic           hit;
  logic [AW-1:0]  hit_pos;
  logic           last;
  logic [PW-1:0]  lane_pos;
  logic [PW-1:0]  pos_adv;

  // lowest lane wins: walk lanes downward so the nearest hit is kept
  always_comb begin
    hit      = 1'b0;
    hit_pos  = '0;
    lane_pos = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      lane_pos = {1'b0, pos} + PW'(i);
      if (lane_pos >= PW'(ACT)) begin
        lane_pos = lane_pos - PW'(ACT);
      end
      if (flags[lane_pos[AW-1:0]]) begin
        hit     = 1'b1;
        hit_pos = lane_pos[AW-1:0];
      end
    end
  end

  always_comb begin
    pos_adv = {1'b0, pos} + PW'(LANES);
    if (pos_adv >= PW'(ACT)) begin
      pos_adv = pos_adv - PW'(ACT);
    end
  end

  assign last       = (chunk == CHW'(NCHUNK - 1));
  assign res.done   = busy & (hit | last);
  assign res.found  = busy & hit;
  assign res.client = CID_W'(hit_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (res.done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pos   <= start_pos;
      chunk <= '0;
    end else if (busy && !last) begin
      pos   <= pos_adv[AW-1:0];
      chunk <= chunk + CHW'(1);
    end
  end

  a_chunk_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> chunk <= CHW'(NCHUNK - 1))
    else $error("scan ran past its last chunk");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("scan restarted while busy");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    busy && !res.done && !start |=> busy && chunk == $past(chunk) + CHW'(1))
    else $error("scan stalled without finishing");

  a_found_flag: assert property (@(posedge clk) disable iff (rst)
    res.found |-> flags[res.client[AW-1:0]])
    else $error("scan granted a client with no pending work");

endmodule

// ===== hdl/request_scheduler_fifo_rr_top.sv =====
// Request scheduler top level: FIFO or round-robin service of client requests.
//
// One word is taken at a time. An enqueue, a FIFO take and any word that is
// rejected outright read the client or queue memory, where needed, when
// accepted, then update it and register the response in S_EXEC. A round-robin
// take first scans in S_SCAN, walking 8-client chunks from the client after
// the last one served until it finds pending work, at most ceil(N/8) chunks
// with N = min(CLIENTS, 64), then updates in S_EXEC. A stalled response holds
// the block in S_EXEC. Only client ids 0..63 exist, so per-client state is
// sized to N entries; its entries carry reset-cleared valid bits, so no
// clearing pass follows reset. The user must write configuration (cfg_we,
// cfg_index, cfg_data) only while no word is in flight; the block does not enforce it.
module request_scheduler_fifo_rr_top #(
  parameter int CLIENTS     = 64,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rsfrr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsfrr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  rsfrr_pkg::req_word_t                req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output rsfrr_pkg::rsp_word_t                rsp
);
  import rsfrr_pkg::*;

  localparam int ACT = (CLIENTS < 2**CID_W) ? CLIENTS : 2**CID_W;
  localparam int AW  = $clog2(ACT);
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int FW  = QW + 1;
  localparam int EW  = PEND_W + 1;
  localparam logic [CID_W:0] ACT_LIM = (CID_W + 1)'(ACT);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  localparam logic [1:0] X_ENQ   = 2'd0;
  localparam logic [1:0] X_POP   = 2'd1;
  localparam logic [1:0] X_GRANT = 2'd2;
  localparam logic [1:0] X_FIXED = 2'd3;

  logic [1:0]         state;
  logic [1:0]         xkind;
  logic [CID_W-1:0]   cid;
  logic [ST_W-1:0]    fixed_status;
  logic               policy;
  logic [LIMIT_W-1:0] admit_limit;
  logic [LIMIT_W-1:0] seen_total;
  logic [QW-1:0]      head;
  logic [QW-1:0]      tail;
  logic [FW-1:0]      fill;
  logic [AW-1:0]      last_served;
  logic [ACT-1:0]     nz;
  logic [ACT-1:0]     cm_vld;

  // client memory entry: {seen, pending count}
  logic [EW-1:0]    client_mem [ACT];
  logic [CID_W-1:0] order_mem  [QUEUE_DEPTH];
  logic [EW-1:0]    cm_q;
  logic             cm_q_vld;
  logic [CID_W-1:0] oq_q;

  logic             accept;
  logic             free;
  logic             fire;
  logic             id_ok;
  logic             scan_start;
  logic [AW-1:0]    start_pos;
  scan_res_t        scan;
  logic             cm_rd_en;
  logic [AW-1:0]    cm_rd_addr;
  logic             oq_rd_en;

  logic [EW-1:0]     ent;
  logic              e_seen;
  logic [PEND_W-1:0] e_pend;
  logic [ST_W-1:0]   ex_status;
  logic [CID_W-1:0]  ex_client;
  logic              cm_we;
  logic [EW-1:0]     cm_wr_data;
  logic              q_push;
  logic              q_pop;
  logic              grant;
  logic              bump_seen;

  assign req_stall  = (state != S_IDLE);
  assign accept     = req_valid & ~req_stall;
  assign free       = ~rsp_valid | ~rsp_stall;
  assign fire       = (state == S_EXEC) & free;
  assign id_ok      = {1'b0, req.client_id} < ACT_LIM;
  assign scan_start = accept & (req.func == FUNC_TAKE) & (policy == POLICY_RR);
  assign start_pos  = (last_served == AW'(ACT - 1)) ? '0 : last_served + AW'(1);

  assign cm_rd_en   = (accept & (req.func == FUNC_ENQ) & id_ok) |
                      ((state == S_SCAN) & scan.found);
  assign cm_rd_addr = (state == S_SCAN) ? scan.client[AW-1:0] : req.client_id[AW-1:0];
  assign oq_rd_en   = accept & (req.func == FUNC_TAKE) & (policy == POLICY_FIFO) &
                      (fill != '0);

  rsfrr_scan #(
    .ACT (ACT)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .start_pos (start_pos),
    .flags     (nz),
    .res       (scan)
  );

  // entries never written read as zero
  assign ent    = cm_q_vld ? cm_q : '0;
  assign e_seen = ent[EW-1];
  assign e_pend = ent[PEND_W-1:0];

  always_comb begin
    ex_status  = fixed_status;
    ex_client  = '0;
    cm_we      = 1'b0;
    cm_wr_data = ent;
    q_push     = 1'b0;
    q_pop      = 1'b0;
    grant      = 1'b0;
    bump_seen  = 1'b0;
    case (xkind)
      X_ENQ: begin
        if (!e_seen && seen_total >= admit_limit) begin
          ex_status = ST_LIMIT;
        end else if (policy == POLICY_FIFO) begin
          if (fill == FW'(QUEUE_DEPTH)) begin
            ex_status = ST_FULL;
          end else begin
            ex_status  = ST_OK;
            q_push     = 1'b1;
            cm_we      = 1'b1;
            cm_wr_data = {1'b1, e_pend};
            bump_seen  = ~e_seen;
          end
        end else if (e_pend == PENDING_MAX) begin
          ex_status = ST_FULL;
        end else begin
          ex_status  = ST_OK;
          cm_we      = 1'b1;
          cm_wr_data = {1'b1, e_pend + PEND_W'(1)};
          bump_seen  = ~e_seen;
        end
      end
      X_POP: begin
        ex_status = ST_OK;
        ex_client = oq_q;
        q_pop     = 1'b1;
      end
      X_GRANT: begin
        ex_status  = ST_OK;
        ex_client  = cid;
        cm_we      = 1'b1;
        cm_wr_data = {e_seen, e_pend - PEND_W'(1)};
        grant      = 1'b1;
      end
      X_FIXED: begin
        ex_status = fixed_status;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      policy      <= POLICY_FIFO;
      admit_limit <= LIMIT_RESET;
      seen_total  <= '0;
      head        <= '0;
      tail        <= '0;
      fill        <= '0;
      last_served <= AW'(ACT - 1);
      nz          <= '0;
      cm_vld      <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POLICY: policy <= cfg_data[0];
          CFG_LIMIT:  admit_limit <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= scan_start ? S_SCAN : S_EXEC;
          end
        end
        S_SCAN: begin
          if (scan.done) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (fire) begin
        rsp_valid <= 1'b1;
        if (cm_we) begin
          cm_vld[cid[AW-1:0]] <= 1'b1;
          nz[cid[AW-1:0]]     <= (cm_wr_data[PEND_W-1:0] != '0);
        end
        if (bump_seen) begin
          seen_total <= seen_total + LIMIT_W'(1);
        end
        if (q_push) begin
          tail <= (tail == QW'(QUEUE_DEPTH - 1)) ? '0 : tail + QW'(1);
          fill <= fill + FW'(1);
        end
        if (q_pop) begin
          head <= (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + QW'(1);
          fill <= fill - FW'(1);
        end
        if (grant) begin
          last_served <= cid[AW-1:0];
        end
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // word being worked on
  always_ff @(posedge clk) begin
    if (accept) begin
      cid          <= req.client_id;
      xkind        <= X_FIXED;
      fixed_status <= ST_NONE;
      if (req.func == FUNC_ENQ) begin
        if (id_ok) begin
          xkind <= X_ENQ;
        end else begin
          fixed_status <= ST_LIMIT;
        end
      end else if (policy == POLICY_FIFO && fill != '0) begin
        xkind <= X_POP;
      end
    end else if (state == S_SCAN && scan.found) begin
      cid   <= scan.client;
      xkind <= X_GRANT;
    end
    if (fire) begin
      rsp.status         <= ex_status;
      rsp.granted_client <= ex_client;
    end
  end

  // client memory: one read, one write port
  always_ff @(posedge clk) begin
    if (cm_rd_en) begin
      cm_q     <= client_mem[cm_rd_addr];
      cm_q_vld <= cm_vld[cm_rd_addr];
    end
    if (fire && cm_we) begin
      client_mem[cid[AW-1:0]] <= cm_wr_data;
    end
  end

  // shared order queue
  always_ff @(posedge clk) begin
    if (oq_rd_en) begin
      oq_q <= order_mem[head];
    end
    if (fire && q_push) begin
      order_mem[tail] <= cid;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    fill == '0 |-> head == tail)
    else $error("empty queue with pointers apart");

  a_seen_range: assert property (@(posedge clk) disable iff (rst)
    seen_total <= LIMIT_W'(ACT))
    else $error("more clients seen than exist");

  a_grant_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC && xkind == X_GRANT |-> nz[cid[AW-1:0]])
    else $error("grant to a client with nothing pending");

  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_EXEC)
    else $error("response raised outside the update cycle");

endmodule
